>>> sv/round_robin_task_slot_scheduler_core_defines.svh
// Assertion macros used by the scheduler datapath.
`ifndef ROUND_ROBIN_TASK_SLOT_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_TASK_SLOT_SCHEDULER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define RRTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RRTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> sv/rrts_pkg.sv
// Types, constants and controller/datapath command and status structs of the scheduler.
package rrts_pkg;

    localparam int SLOT_COUNT_DEF    = 16;
    localparam int CONTEXT_WIDTH_DEF = 32;

    localparam int REQ_W      = 2;
    localparam int MASK_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int OUT_SLOT_W = 4;
    localparam int OUT_CTX_W  = 32;
    localparam int OUT_LIVE_W = 5;
    localparam int EXT_W      = 64;

    typedef enum logic [REQ_W-1:0] {
        REQ_INIT   = 2'd0,
        REQ_CREATE = 2'd1,
        REQ_SCHED  = 2'd2,
        REQ_EXIT   = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE    = 2'd0,
        STS_REFUSED = 2'd1,
        STS_FAULT   = 2'd2,
        STS_HALTED  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_READY   = 2'd1,
        SLOT_RUNNING = 2'd2,
        SLOT_DEAD    = 2'd3
    } t_slot_st;

    typedef enum logic [1:0] {
        RD_CUR   = 2'd0,
        RD_START = 2'd1,
        RD_NEXT  = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    in_ready;
        logic    load_req;
        logic    do_init;
        logic    set_status;
        t_status status;
        logic    mark_dead;
        logic    save_cur;
        logic    scan_start;
        logic    scan_step;
        logic    create_commit;
        logic    switch_commit;
        logic    halt;
        logic    ctx_capture;
        logic    resp_load;
        t_rd_sel rd_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic halted;
        logic initialized;
        t_req req;
        logic create_full;
        logic live_zero;
        logic guard_cur_ok;
        logic scan_hit;
        logic scan_last;
        logic guard_nx_ok;
        logic out_busy;
    } t_dp_sts;

endpackage

>>> sv/rrts_req_if.sv
// Request channel: valid/ready handshake with the request fields.
interface rrts_req_if #(
    parameter int CONTEXT_WIDTH = rrts_pkg::CONTEXT_WIDTH_DEF
);
    import rrts_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [CONTEXT_WIDTH-1:0] context_in;
    logic [MASK_W-1:0]        stack_ok_mask;

    modport source (output valid, output req_type, output context_in, output stack_ok_mask,
                    input ready);
    modport sink   (input valid, input req_type, input context_in, input stack_ok_mask,
                    output ready);
endinterface

>>> sv/rrts_rsp_if.sv
// Result channel: valid/ready handshake with the result fields.
interface rrts_rsp_if;
    import rrts_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [OUT_SLOT_W-1:0] created_slot;
    logic                  switched;
    logic [OUT_CTX_W-1:0]  next_context;
    logic [OUT_SLOT_W-1:0] running_slot;
    logic [OUT_LIVE_W-1:0] live_tasks;
    logic                  table_ready;

    modport source (output valid, output status, output created_slot, output switched,
                    output next_context, output running_slot, output live_tasks,
                    output table_ready, input ready);
    modport sink   (input valid, input status, input created_slot, input switched,
                    input next_context, input running_slot, input live_tasks,
                    input table_ready, output ready);
endinterface

>>> sv/rrts_ctrl.sv
// Scheduler controller: sequences each request through evaluate, scan, context read and reply.
module rrts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rrts_pkg::t_dp_sts i_sts,
    output rrts_pkg::t_dp_cmd o_cmd
);
    import rrts_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_CHK  = 5'b00100,
        S_CTX  = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.status = STS_DONE;
        o_cmd.rd_sel = RD_CUR;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EVAL;
                end
            end
            S_EVAL: begin
                // The first slot of a possible scan is read here whatever the outcome.
                o_cmd.rd_sel = RD_START;
                if (i_sts.halted) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = STS_HALTED;
                    n_state          = S_RESP;
                end else if (i_sts.req == REQ_INIT) begin
                    o_cmd.do_init    = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = STS_DONE;
                    n_state          = S_RESP;
                end else if (!i_sts.initialized) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = STS_REFUSED;
                    n_state          = S_RESP;
                end else if (i_sts.req == REQ_CREATE) begin
                    if (i_sts.create_full) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = STS_REFUSED;
                        n_state          = S_RESP;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_CHK;
                    end
                end else begin
                    // An exiting task is marked dead even if nothing is left to run.
                    o_cmd.mark_dead = (i_sts.req == REQ_EXIT);
                    if (i_sts.live_zero) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = STS_REFUSED;
                        n_state          = S_RESP;
                    end else if (!i_sts.guard_cur_ok) begin
                        o_cmd.halt       = 1'b1;
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = STS_FAULT;
                        n_state          = S_RESP;
                    end else begin
                        o_cmd.save_cur   = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_CHK;
                    end
                end
            end
            S_CHK: begin
                o_cmd.rd_sel = RD_NEXT;
                if (i_sts.req == REQ_CREATE) begin
                    if (i_sts.scan_hit) begin
                        o_cmd.create_commit = 1'b1;
                        o_cmd.set_status    = 1'b1;
                        o_cmd.status        = STS_DONE;
                        n_state             = S_RESP;
                    end else if (i_sts.scan_last) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = STS_REFUSED;
                        n_state          = S_RESP;
                    end else begin
                        o_cmd.scan_step = 1'b1;
                    end
                end else if (i_sts.scan_hit || i_sts.scan_last) begin
                    if (!i_sts.guard_nx_ok) begin
                        o_cmd.halt       = 1'b1;
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = STS_FAULT;
                        n_state          = S_RESP;
                    end else begin
                        o_cmd.switch_commit = 1'b1;
                        o_cmd.set_status    = 1'b1;
                        o_cmd.status        = STS_DONE;
                        n_state             = S_CTX;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_CTX: begin
                o_cmd.ctx_capture = 1'b1;
                n_state           = S_RESP;
            end
            S_RESP: begin
                if (!i_sts.out_busy) begin
                    o_cmd.resp_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/rrts_dp.sv
// Scheduler datapath: slot tables, scheduler registers, scan pointer and the result register.
`include "round_robin_task_slot_scheduler_core_defines.svh"

module rrts_dp #(
    parameter int SLOT_COUNT    = rrts_pkg::SLOT_COUNT_DEF,
    parameter int CONTEXT_WIDTH = rrts_pkg::CONTEXT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rrts_pkg::t_dp_cmd i_cmd,
    output rrts_pkg::t_dp_sts o_sts,
    rrts_req_if.sink          i_req,
    rrts_rsp_if.source        o_rsp
);
    import rrts_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int LW = $clog2(SLOT_COUNT + 1);

    function automatic logic is_live(input t_slot_st s);
        return (s == SLOT_READY) || (s == SLOT_RUNNING);
    endfunction

    // Latched request.
    t_req                     r_req;
    logic [CONTEXT_WIDTH-1:0] r_ctx_in;
    logic [MASK_W-1:0]        r_mask;

    // Scheduler state.
    logic [SW-1:0] r_cur;
    logic [LW-1:0] r_created;
    logic [LW-1:0] r_live;
    logic          r_init;
    logic          r_halted;
    logic [SW-1:0] r_scan_idx;
    logic [SW-1:0] r_scan_cnt;

    // Slot state memory; an entry without its valid bit reads as free.
    t_slot_st                 r_state_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]    r_state_vld;
    t_slot_st                 r_state_q;
    logic                     r_state_qv;
    logic [CONTEXT_WIDTH-1:0] r_ctx_mem [SLOT_COUNT];
    logic [CONTEXT_WIDTH-1:0] r_ctx_q;

    // Result being built and the output register.
    t_status                  r_res_status;
    logic [SW-1:0]            r_res_made;
    logic                     r_res_sw;
    logic [CONTEXT_WIDTH-1:0] r_res_ctx;
    logic                     r_out_valid;
    t_status                  r_out_status;
    logic [OUT_SLOT_W-1:0]    r_out_made;
    logic                     r_out_sw;
    logic [OUT_CTX_W-1:0]     r_out_ctx;
    logic [OUT_SLOT_W-1:0]    r_out_cur;
    logic [OUT_LIVE_W-1:0]    r_out_live;
    logic                     r_out_init;

    logic [LW-1:0] n_live;

    t_slot_st              w_state_rd;
    logic [SLOT_COUNT-1:0] w_ok_vec;
    logic [SW-1:0]         w_cur_next;
    logic [SW-1:0]         w_scan_next;
    logic [SW-1:0]         w_start;
    logic [SW-1:0]         w_nx;
    logic [SW-1:0]         w_rd_addr;
    logic                  w_dec;
    logic [LW-1:0]         w_live_after;
    logic                  w_scan_hit;
    logic                  w_st_we;
    logic [SW-1:0]         w_st_addr;
    t_slot_st              w_st_data;
    logic                  w_ctx_we;
    logic [SW-1:0]         w_ctx_addr;
    logic [EXT_W-1:0]      w_ext_made;
    logic [EXT_W-1:0]      w_ext_cur;
    logic [EXT_W-1:0]      w_ext_live;
    logic [EXT_W-1:0]      w_ext_ctx;

    // Slots beyond the guard mask have no guard word and always pass.
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_ok
        if (g < MASK_W) begin : g_guarded
            assign w_ok_vec[g] = r_mask[g];
        end else begin : g_unguarded
            assign w_ok_vec[g] = 1'b1;
        end
    end

    assign w_state_rd   = r_state_qv ? r_state_q : SLOT_FREE;
    assign w_cur_next   = (r_cur == SW'(SLOT_COUNT - 1)) ? '0 : r_cur + SW'(1);
    assign w_scan_next  = (r_scan_idx == SW'(SLOT_COUNT - 1)) ? '0 : r_scan_idx + SW'(1);
    assign w_start      = (r_req == REQ_CREATE) ? '0 : w_cur_next;
    assign w_scan_hit   = (r_req == REQ_CREATE) ? (w_state_rd == SLOT_FREE)
                                                : (w_state_rd == SLOT_READY);
    // With no ready slot found the current slot runs again.
    assign w_nx         = w_scan_hit ? r_scan_idx : r_cur;
    assign w_dec        = (r_req == REQ_EXIT) && is_live(w_state_rd);
    assign w_live_after = r_live - LW'(w_dec);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_CUR:   w_rd_addr = r_cur;
            RD_START: w_rd_addr = w_start;
            RD_NEXT:  w_rd_addr = w_scan_next;
            default:  w_rd_addr = r_cur;
        endcase
    end

    always_comb begin
        w_st_we   = 1'b0;
        w_st_addr = r_cur;
        w_st_data = SLOT_READY;
        if (i_cmd.mark_dead) begin
            w_st_we   = 1'b1;
            w_st_data = SLOT_DEAD;
        end else if (i_cmd.save_cur) begin
            // A dead slot stays dead; only its context is saved.
            w_st_we   = (w_state_rd != SLOT_DEAD);
            w_st_data = SLOT_READY;
        end else if (i_cmd.create_commit) begin
            w_st_we   = 1'b1;
            w_st_addr = r_scan_idx;
            w_st_data = SLOT_READY;
        end else if (i_cmd.switch_commit) begin
            w_st_we   = 1'b1;
            w_st_addr = w_nx;
            w_st_data = SLOT_RUNNING;
        end
    end

    assign w_ctx_we   = i_cmd.save_cur || i_cmd.create_commit;
    assign w_ctx_addr = i_cmd.create_commit ? r_scan_idx : r_cur;

    always_comb begin
        n_live = r_live;
        if (i_cmd.do_init) begin
            n_live = '0;
        end else begin
            if (i_cmd.mark_dead && w_dec) begin
                n_live = n_live - LW'(1);
            end
            // Scheduling from a free slot puts that slot in the ready set.
            if (i_cmd.save_cur && (r_req != REQ_EXIT) && (w_state_rd == SLOT_FREE)) begin
                n_live = n_live + LW'(1);
            end
            if (i_cmd.create_commit) begin
                n_live = n_live + LW'(1);
            end
            if (i_cmd.switch_commit && !is_live(w_state_rd)) begin
                n_live = n_live + LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            r_state_mem[w_st_addr] <= w_st_data;
        end
        r_state_q  <= r_state_mem[w_rd_addr];
        r_state_qv <= r_state_vld[w_rd_addr];
        if (w_ctx_we) begin
            r_ctx_mem[w_ctx_addr] <= r_ctx_in;
        end
        r_ctx_q <= r_ctx_mem[w_nx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_vld <= '0;
            r_cur       <= '0;
            r_created   <= '0;
            r_live      <= '0;
            r_init      <= 1'b0;
            r_halted    <= 1'b0;
        end else begin
            r_live <= n_live;
            if (i_cmd.do_init) begin
                r_state_vld <= '0;
                r_cur       <= '0;
                r_created   <= '0;
                r_init      <= 1'b1;
            end else if (w_st_we) begin
                r_state_vld[w_st_addr] <= 1'b1;
            end
            if (i_cmd.create_commit) begin
                r_created <= r_created + LW'(1);
            end
            if (i_cmd.switch_commit) begin
                r_cur <= w_nx;
            end
            if (i_cmd.halt) begin
                r_halted <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req        <= t_req'(i_req.req_type);
            r_ctx_in     <= i_req.context_in;
            r_mask       <= i_req.stack_ok_mask;
            r_res_status <= STS_REFUSED;
            r_res_made   <= '0;
            r_res_sw     <= 1'b0;
            r_res_ctx    <= '0;
        end
        if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status;
        end
        if (i_cmd.create_commit) begin
            r_res_made <= r_scan_idx;
        end
        if (i_cmd.switch_commit) begin
            r_res_sw <= 1'b1;
        end
        if (i_cmd.ctx_capture) begin
            r_res_ctx <= r_ctx_q;
        end
        if (i_cmd.scan_start) begin
            r_scan_idx <= w_start;
            r_scan_cnt <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= w_scan_next;
            r_scan_cnt <= r_scan_cnt + SW'(1);
        end
    end

    assign w_ext_made = EXT_W'(r_res_made);
    assign w_ext_cur  = EXT_W'(r_cur);
    assign w_ext_live = EXT_W'(r_live);
    assign w_ext_ctx  = EXT_W'(r_res_ctx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.resp_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp_load) begin
            r_out_status <= r_res_status;
            r_out_made   <= w_ext_made[OUT_SLOT_W-1:0];
            r_out_sw     <= r_res_sw;
            r_out_ctx    <= w_ext_ctx[OUT_CTX_W-1:0];
            r_out_cur    <= w_ext_cur[OUT_SLOT_W-1:0];
            r_out_live   <= w_ext_live[OUT_LIVE_W-1:0];
            r_out_init   <= r_init;
        end
    end

    assign i_req.ready        = i_cmd.in_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.created_slot = r_out_made;
    assign o_rsp.switched     = r_out_sw;
    assign o_rsp.next_context = r_out_ctx;
    assign o_rsp.running_slot = r_out_cur;
    assign o_rsp.live_tasks   = r_out_live;
    assign o_rsp.table_ready  = r_out_init;

    always_comb begin
        o_sts              = '0;
        o_sts.in_valid     = i_req.valid;
        o_sts.halted       = r_halted;
        o_sts.initialized  = r_init;
        o_sts.req          = r_req;
        o_sts.create_full  = (r_created >= LW'(SLOT_COUNT));
        o_sts.live_zero    = (w_live_after == '0);
        o_sts.guard_cur_ok = w_ok_vec[r_cur];
        o_sts.scan_hit     = w_scan_hit;
        o_sts.scan_last    = (r_scan_cnt == SW'(SLOT_COUNT - 1));
        o_sts.guard_nx_ok  = w_ok_vec[w_nx];
        o_sts.out_busy     = r_out_valid && !o_rsp.ready;
    end

    `RRTS_ASSERT_IMPLY(a_live_range, i_clk, i_rst_n, 1'b1, r_live <= LW'(SLOT_COUNT), "live count above slot count")
    `RRTS_ASSERT_IMPLY(a_created_range, i_clk, i_rst_n, 1'b1, r_created <= LW'(SLOT_COUNT), "create count above slot count")
    `RRTS_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_halted, r_halted, "halt cleared without reset")
    `RRTS_ASSERT_IMPLY(a_switch_guard, i_clk, i_rst_n, i_cmd.switch_commit, w_ok_vec[w_nx] && !r_halted, "switch to a slot with a bad guard")

endmodule

>>> sv/round_robin_task_slot_scheduler_core.sv
// Round-robin task slot scheduler: top level joining the controller and the datapath.
//
// The scheduler keeps SLOT_COUNT task slots, each with a state and a saved context,
// and answers every request with exactly one result. Requests are handled one at a
// time. Init, halted and requests refused at evaluation go straight to the reply;
// a create scans the slots before the reply, and a schedule or exit that switches
// scans and then reads the new slot's context. The slot search reads the
// slot-state memory one slot per cycle, starting at slot 0 for a create and at
// the slot after the running one for a schedule or exit. A new request is taken
// while the previous result still waits in the output register. After a stack guard
// fault the block answers every request with the halted status until reset.
module round_robin_task_slot_scheduler_core #(
    parameter int SLOT_COUNT    = rrts_pkg::SLOT_COUNT_DEF,
    parameter int CONTEXT_WIDTH = rrts_pkg::CONTEXT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrts_req_if.sink   i_req,
    rrts_rsp_if.source o_rsp
);
    import rrts_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    rrts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    rrts_dp #(
        .SLOT_COUNT    (SLOT_COUNT),
        .CONTEXT_WIDTH (CONTEXT_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

>>> verif/tb.sv
// Self-checking testbench for the round-robin task slot scheduler core.
`timescale 1ns / 1ps

module tb;
    import rrts_pkg::*;

    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        t_status     status;
        logic [3:0]  created_slot;
        logic        switched;
        logic [31:0] next_context;
        logic [3:0]  running_slot;
        logic [4:0]  live_tasks;
        logic        table_ready;
    } t_sched_outcome;

    logic i_clk;
    logic i_rst_n;

    rrts_req_if req_ch ();
    rrts_rsp_if rsp_ch ();

    round_robin_task_slot_scheduler_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the slot table.
    t_slot_st    slot_st [SLOTS];
    logic [31:0] slot_ctx [SLOTS];
    logic [3:0]  cur_slot;
    int          created_cnt;
    bit          table_init;
    bit          is_halted;

    t_sched_outcome awaited_outcomes[$];
    int             failure_count;
    int             cycle_count;
    int             burst_left;
    bit             steady;

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL round_robin_task_slot_scheduler_core");
            $finish;
        end
    end

    function automatic int count_live_slots();
        int n;
        n = 0;
        foreach (slot_st[i])
            if (slot_st[i] == SLOT_READY || slot_st[i] == SLOT_RUNNING)
                n++;
        return n;
    endfunction

    function automatic logic [15:0] rand_mask();
        return 16'($urandom);
    endfunction

    // The running slot is looked at last, so it is chosen again only when no other
    // slot is ready.
    function automatic logic [3:0] next_ready();
        logic [3:0] n;
        n = cur_slot;
        for (int i = 0; i < SLOTS; i++) begin
            n = n + 4'd1;
            if (slot_st[n] == SLOT_READY)
                return n;
        end
        return cur_slot;
    endfunction

    function automatic t_sched_outcome apply_request(t_req kind, logic [31:0] ctx,
                                                     logic [15:0] mask);
        t_sched_outcome r;
        int             si;
        logic [3:0]     nx;
        r = '0;
        r.status = STS_REFUSED;
        if (is_halted) begin
            r.status = STS_HALTED;
        end else if (kind == REQ_INIT) begin
            foreach (slot_st[i])
                slot_st[i] = SLOT_FREE;
            created_cnt = 0;
            cur_slot = '0;
            table_init = 1'b1;
            r.status = STS_DONE;
        end else if (table_init && kind == REQ_CREATE) begin
            si = 0;
            while (si < SLOTS && slot_st[si[3:0]] != SLOT_FREE)
                si++;
            if (created_cnt < SLOTS && si < SLOTS) begin
                slot_ctx[si[3:0]] = ctx;
                slot_st[si[3:0]] = SLOT_READY;
                created_cnt++;
                r.created_slot = si[3:0];
                r.status = STS_DONE;
            end
        end else if (table_init) begin
            if (kind == REQ_EXIT)
                slot_st[cur_slot] = SLOT_DEAD;
            if (count_live_slots() != 0) begin
                if (!mask[cur_slot]) begin
                    is_halted = 1'b1;
                    r.status = STS_FAULT;
                end else begin
                    slot_ctx[cur_slot] = ctx;
                    if (slot_st[cur_slot] != SLOT_DEAD)
                        slot_st[cur_slot] = SLOT_READY;
                    nx = next_ready();
                    if (!mask[nx]) begin
                        is_halted = 1'b1;
                        r.status = STS_FAULT;
                    end else begin
                        cur_slot = nx;
                        slot_st[nx] = SLOT_RUNNING;
                        r.next_context = slot_ctx[nx];
                        r.switched = 1'b1;
                        r.status = STS_DONE;
                    end
                end
            end
        end
        r.running_slot = cur_slot;
        r.live_tasks = 5'(count_live_slots());
        r.table_ready = table_init;
        return r;
    endfunction

    // Keeps the guard bits of the outgoing and the incoming slot intact, since a
    // fault halts the block until reset.
    function automatic logic [15:0] safe_mask(t_req kind, logic [15:0] m);
        if (kind == REQ_SCHED || kind == REQ_EXIT) begin
            m[cur_slot] = 1'b1;
            m[next_ready()] = 1'b1;
        end
        return m;
    endfunction

    task automatic send_request(t_req kind, logic [31:0] ctx, logic [15:0] mask);
        int gap;
        if (!steady && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left != 0)
            burst_left--;
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= kind;
        req_ch.context_in    <= ctx;
        req_ch.stack_ok_mask <= mask;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        awaited_outcomes.push_back(apply_request(kind, ctx, mask));
    endtask

    task automatic send_safe(t_req kind, logic [31:0] ctx, logic [15:0] mask);
        send_request(kind, ctx, safe_mask(kind, mask));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (awaited_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            failure_count++;
        end
    endfunction

    function automatic void check_outcome();
        t_sched_outcome e;
        if (awaited_outcomes.size() == 0) begin
            $error("result arrived with no request outstanding");
            failure_count++;
        end else begin
            e = awaited_outcomes.pop_front();
            check_field("status", 32'(e.status), 32'(rsp_ch.status));
            check_field("created_slot", 32'(e.created_slot), 32'(rsp_ch.created_slot));
            check_field("switched", 32'(e.switched), 32'(rsp_ch.switched));
            check_field("next_context", e.next_context, rsp_ch.next_context);
            check_field("running_slot", 32'(e.running_slot), 32'(rsp_ch.running_slot));
            check_field("live_tasks", 32'(e.live_tasks), 32'(rsp_ch.live_tasks));
            check_field("table_ready", 32'(e.table_ready), 32'(rsp_ch.table_ready));
        end
    endfunction

    // The result side stalls on a pattern picked from the cycle counter, but not while steady.
    always @(posedge i_clk) begin
        logic take;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            check_outcome();
        if (steady) begin
            take = 1'b1;
        end else begin
            case (cycle_count[8:7])
                2'd0:    take = 1'b1;
                2'd1:    take = 1'($urandom_range(0, 1));
                2'd2:    take = (cycle_count[1:0] == 2'd0);
                default: take = ($urandom_range(0, 7) != 0);
            endcase
        end
        rsp_ch.ready <= take;
    end

    // Everything but init is refused until the table has been set up.
    task automatic test_before_init();
        send_request(REQ_CREATE, 32'hFFFF_FFFF, 16'h0000);
        send_request(REQ_SCHED, 32'h0000_0000, 16'hFFFF);
        send_request(REQ_EXIT, $urandom, rand_mask());
    endtask

    task automatic test_directed_table();
        send_safe(REQ_INIT, $urandom, rand_mask());
        // Nothing is live yet: schedule does nothing, exit still kills slot 0.
        send_safe(REQ_SCHED, $urandom, rand_mask());
        send_safe(REQ_EXIT, $urandom, rand_mask());
        send_safe(REQ_CREATE, 32'h0000_0000, rand_mask());
        send_safe(REQ_SCHED, 32'hFFFF_FFFF, rand_mask());
        // A single task is picked again on every tick.
        send_safe(REQ_INIT, $urandom, rand_mask());
        send_safe(REQ_CREATE, 32'hFFFF_FFFF, rand_mask());
        send_safe(REQ_SCHED, 32'h0000_0000, rand_mask());
        send_safe(REQ_SCHED, 32'hFFFF_FFFF, rand_mask());
        // The last task exits and leaves nothing to run.
        send_safe(REQ_EXIT, $urandom, rand_mask());
        send_safe(REQ_SCHED, $urandom, rand_mask());
    endtask

    task automatic test_random_traffic();
        int   sent;
        int   pick;
        bit   paused;
        t_req kind;
        sent = 0;
        paused = 1'b0;
        while (sent < 1000) begin
            steady = (sent >= 600 && sent < 700);
            send_safe(REQ_INIT, $urandom, rand_mask());
            sent++;
            // Up to one create more than the table holds.
            repeat ($urandom_range(1, SLOTS + 1)) begin
                send_safe(REQ_CREATE, $urandom, rand_mask());
                sent++;
            end
            repeat ($urandom_range(10, 60)) begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    kind = REQ_INIT;
                else if (pick < 20)
                    kind = REQ_CREATE;
                else if (pick < 82)
                    kind = REQ_SCHED;
                else
                    kind = REQ_EXIT;
                send_safe(kind, $urandom, rand_mask());
                sent++;
            end
            if (!paused && sent >= 500) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        steady = 1'b0;
    endtask

    // A guard fault halts the block for the rest of the run, so this comes last.
    task automatic test_stack_fault();
        logic [15:0] m;
        send_safe(REQ_INIT, $urandom, rand_mask());
        repeat (3) send_safe(REQ_CREATE, $urandom, rand_mask());
        send_safe(REQ_SCHED, $urandom, rand_mask());
        m = rand_mask();
        if ($urandom_range(0, 1) == 0) begin
            m[cur_slot] = 1'b0;
        end else begin
            m[cur_slot] = 1'b1;
            m[next_ready()] = 1'b0;
        end
        send_request(REQ_SCHED, $urandom, m);
        send_request(REQ_INIT, $urandom, 16'hFFFF);
        send_request(REQ_CREATE, $urandom, 16'hFFFF);
        send_request(REQ_SCHED, $urandom, 16'hFFFF);
        send_request(REQ_EXIT, $urandom, 16'hFFFF);
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_INIT;
        req_ch.context_in = '0;
        req_ch.stack_ok_mask = '0;
        rsp_ch.ready = 1'b0;
        cycle_count = 0;
        failure_count = 0;
        burst_left = 0;
        steady = 1'b0;
        foreach (slot_st[i]) begin
            slot_st[i] = SLOT_FREE;
            slot_ctx[i] = '0;
        end
        cur_slot = '0;
        created_cnt = 0;
        table_init = 1'b0;
        is_halted = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_before_init();
        test_directed_table();
        test_random_traffic();
        test_stack_fault();

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (failure_count == 0)
            $display("PASS round_robin_task_slot_scheduler_core");
        else
            $display("FAIL round_robin_task_slot_scheduler_core");
        $finish;
    end

endmodule
